// ----- hdl/lbpg_pkg.sv -----
package lbpg_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int NOW_WIDTH  = 32;
  localparam int ADDR_WIDTH = 3;
  localparam int DATA_WIDTH = 32;

  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef enum logic [2:0] {
    MODE_SLOW   = 3'd0,
    MODE_NORMAL = 3'd1,
    MODE_FAST   = 3'd2,
    MODE_DOUBLE = 3'd3,
    MODE_TRIPLE = 3'd4,
    MODE_NINETY = 3'd5,
    MODE_ON     = 3'd6,
    MODE_OFF    = 3'd7
  } mode_t;

  typedef enum logic {
    REG_MODE   = 1'b0,
    REG_UNUSED = 1'b1
  } reg_idx_t;

  // Period lengths and toggle points in ms
  localparam int PERIOD_SLOW   = 1900;
  localparam int PERIOD_NORMAL = 900;
  localparam int PERIOD_FAST   = 200;
  localparam int PERIOD_DOUBLE = 1000;
  localparam int PERIOD_TRIPLE = 2000;
  localparam int EDGE_1        = 100;
  localparam int EDGE_2        = 200;
  localparam int EDGE_3        = 300;
  localparam int EDGE_4        = 400;
  localparam int EDGE_5        = 500;

  typedef struct packed {
    logic restart;
    logic level;
  } step_res_t;

endpackage

// ----- hdl/lbpg_level.sv -----
module lbpg_level (
  input  lbpg_pkg::mode_t     mode,
  input  lbpg_pkg::time_t     now,
  input  lbpg_pkg::time_t     start,
  input  logic                held,
  output lbpg_pkg::step_res_t res
);
  import lbpg_pkg::*;

  time_t elapsed;
  logic  ge_e1, ge_e2, ge_e3, ge_e4, ge_e5;
  logic  ge_slow, ge_normal, ge_fast, ge_double, ge_triple;
  logic  past_end;
  logic  lvl;

  assign elapsed   = now - start;
  assign ge_e1     = elapsed >= time_t'(EDGE_1);
  assign ge_e2     = elapsed >= time_t'(EDGE_2);
  assign ge_e3     = elapsed >= time_t'(EDGE_3);
  assign ge_e4     = elapsed >= time_t'(EDGE_4);
  assign ge_e5     = elapsed >= time_t'(EDGE_5);
  assign ge_slow   = elapsed >= time_t'(PERIOD_SLOW);
  assign ge_normal = elapsed >= time_t'(PERIOD_NORMAL);
  assign ge_fast   = elapsed >= time_t'(PERIOD_FAST);
  assign ge_double = elapsed >= time_t'(PERIOD_DOUBLE);
  assign ge_triple = elapsed >= time_t'(PERIOD_TRIPLE);

  always_comb begin
    past_end = 1'b0;
    lvl      = 1'b0;
    case (mode)
      MODE_SLOW: begin
        past_end = ge_slow;
        lvl      = ge_e1;
      end
      MODE_NORMAL: begin
        past_end = ge_normal;
        lvl      = ge_e1;
      end
      MODE_FAST: begin
        past_end = ge_fast;
        lvl      = ge_e1;
      end
      MODE_DOUBLE: begin
        past_end = ge_double;
        lvl      = ge_e1 ^ ge_e2 ^ ge_e3;
      end
      MODE_TRIPLE: begin
        past_end = ge_triple;
        lvl      = ge_e1 ^ ge_e2 ^ ge_e3 ^ ge_e4 ^ ge_e5;
      end
      MODE_NINETY: begin
        past_end = ge_normal;
        lvl      = ~ge_e1;
      end
      MODE_ON: begin
        past_end = 1'b0;
        lvl      = 1'b0;
      end
      MODE_OFF: begin
        past_end = 1'b0;
        lvl      = 1'b1;
      end
      default: begin
        past_end = 1'b0;
        lvl      = 1'b1;
      end
    endcase
  end

  // At the period boundary restart the period and hold the last level
  assign res.restart = past_end;
  assign res.level   = past_end ? held : lvl;

endmodule

// ----- hdl/lbpg_regs.sv -----
module lbpg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lbpg_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [lbpg_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [lbpg_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                pready,
  output lbpg_pkg::mode_t                     mode
);
  import lbpg_pkg::*;

  mode_t    mode_r;
  mode_t    mode_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && idx == REG_MODE) begin
      mode_nxt = mode_t'(pwdata[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SLOW;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_MODE: prdata = {{(DATA_WIDTH-3){1'b0}}, mode_r};
      default:  prdata = '0;
    endcase
  end

  assign mode = mode_r;

endmodule

// ----- hdl/led_blink_pattern_generator.sv -----
// Each input transaction passes the input register and then the result register.
// Throughput: one transaction per cycle while out_stall is low; the pattern logic
// between the two registers reads and updates period start and held level per item.
// Reset (synchronous, rst_n low): pattern slow, period start 0, held level 0
// (LED lit), both pipeline stages empty.
module led_blink_pattern_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lbpg_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [lbpg_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [lbpg_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lbpg_pkg::NOW_WIDTH-1:0]   in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_pin_level
);
  import lbpg_pkg::*;

  mode_t     mode;
  step_res_t res;

  logic  s1_valid_r, s1_valid_nxt;
  time_t s1_now_r, s1_now_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  out_pin_r, out_pin_nxt;
  time_t start_r, start_nxt;
  logic  held_r, held_nxt;
  logic  can_out;
  logic  s2_fire;
  logic  in_fire;

  lbpg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  lbpg_level u_level (
    .mode  (mode),
    .now   (s1_now_r),
    .start (start_r),
    .held  (held_r),
    .res   (res)
  );

  assign can_out  = !out_valid_r || !out_stall;
  assign s2_fire  = s1_valid_r && can_out;
  assign in_stall = s1_valid_r && !can_out;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_now_nxt    = s1_now_r;
    out_valid_nxt = out_valid_r;
    out_pin_nxt   = out_pin_r;
    start_nxt     = start_r;
    held_nxt      = held_r;
    // drain the result register once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s2_fire) begin
      out_valid_nxt = 1'b1;
      out_pin_nxt   = res.level;
      held_nxt      = res.level;
      if (res.restart) begin
        start_nxt = s1_now_r;
      end
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_now_nxt   = time_t'(in_now_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      held_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_now_r  <= s1_now_nxt;
    out_pin_r <= out_pin_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pin_level = out_pin_r;

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a stage is free");

  a_held_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (held_r == out_pin_r))
    else $error("held level differs from delivered level");

  a_always_on: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && mode == MODE_ON) |=> (out_valid_r && !out_pin_r))
    else $error("always-on mode produced a dark pin");

  a_restart_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && res.restart) |=> $stable(held_r))
    else $error("held level changed at a period restart");
`endif

endmodule

// ----- test/tb_led_blink_pattern_generator.sv -----
module tb_led_blink_pattern_generator;
  import lbpg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 650;

  class blink_scoreboard;
    mode_t mode;
    time_t period_start;
    logic held_level;
    logic expected_pins[$];
    int fails;

    function new();
      mode = MODE_SLOW;
      period_start = '0;
      held_level = 1'b0;
      fails = 0;
    endfunction

    function void write_reg(logic [ADDR_WIDTH-1:0] addr, logic [DATA_WIDTH-1:0] data);
      if (reg_idx_t'(addr[2]) == REG_MODE) begin
        mode = mode_t'(data[2:0]);
      end
    endfunction

    // Predict the pin level for one accepted tick and queue it.
    function void note_tick(logic [NOW_WIDTH-1:0] now_ms);
      time_t now_t;
      time_t elapsed;
      time_t period;
      logic lvl;
      now_t = time_t'(now_ms);
      elapsed = now_t - period_start;
      case (mode)
        MODE_ON: begin
          held_level = 1'b0;
        end
        MODE_OFF: begin
          held_level = 1'b1;
        end
        default: begin
          case (mode)
            MODE_SLOW:   period = time_t'(PERIOD_SLOW);
            MODE_NORMAL: period = time_t'(PERIOD_NORMAL);
            MODE_FAST:   period = time_t'(PERIOD_FAST);
            MODE_DOUBLE: period = time_t'(PERIOD_DOUBLE);
            MODE_TRIPLE: period = time_t'(PERIOD_TRIPLE);
            default:     period = time_t'(PERIOD_NORMAL);
          endcase
          if (elapsed >= period) begin
            period_start = now_t;
          end else begin
            lvl = (mode == MODE_NINETY);
            if (elapsed >= time_t'(EDGE_1)) lvl = ~lvl;
            if (mode == MODE_DOUBLE || mode == MODE_TRIPLE) begin
              if (elapsed >= time_t'(EDGE_2)) lvl = ~lvl;
              if (elapsed >= time_t'(EDGE_3)) lvl = ~lvl;
            end
            if (mode == MODE_TRIPLE) begin
              if (elapsed >= time_t'(EDGE_4)) lvl = ~lvl;
              if (elapsed >= time_t'(EDGE_5)) lvl = ~lvl;
            end
            held_level = lvl;
          end
        end
      endcase
      expected_pins.push_back(held_level);
    endfunction

    function void check_pin(logic actual);
      logic exp_pin;
      if (expected_pins.size() == 0) begin
        $error("pin_level: result with no expectation, expected none, actual %0b", actual);
        fails++;
      end else begin
        exp_pin = expected_pins.pop_front();
        if (exp_pin !== actual) begin
          $error("pin_level: expected %0b, actual %0b", exp_pin, actual);
          fails++;
        end
      end
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [NOW_WIDTH-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_pin_level;

  blink_scoreboard sb = new();
  int burst_left = 0;
  int cycle_count = 0;
  int stall_style = 0;

  led_blink_pattern_generator u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_now_ms    (in_now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pin_level(out_pin_level)
  );

  always #2 clk = ~clk;

  // Receiver: drive out_stall according to a randomly chosen stall style.
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) begin
      stall_style <= $urandom_range(0, 3);
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycle_count[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pin(out_pin_level);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one tick, hold it until accepted, then maybe leave a gap.
  task automatic send_tick(input logic [NOW_WIDTH-1:0] t);
    int gap;
    in_valid <= 1'b1;
    in_now_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_rel(input time_t offset);
    send_tick(NOW_WIDTH'(sb.period_start + offset));
  endtask

  // Drop valid and drain the block before touching the register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_WIDTH-1:0] addr, input logic [DATA_WIDTH-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [NOW_WIDTH-1:0] t;
    logic [DATA_WIDTH-1:0] wval;
    time_t landmarks[10];
    int sent;
    int phase;
    int phase_len;
    mode_t pm;
    landmarks = '{100, 200, 300, 400, 500, 900, 1000, 1900, 2000, 0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern: thresholds, period boundary, wrap
    send_tick(32'd0);
    send_tick(32'd99);
    send_tick(32'd100);
    send_tick(32'd1899);
    send_tick(32'd1900);
    send_tick(32'd1999);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0063);

    // Wide value keeps only the low bits; unused index is ignored
    wait_idle();
    apb_write(3'd0, 32'hFFFF_FFF8 | DATA_WIDTH'(MODE_TRIPLE));
    apb_write(3'd4, DATA_WIDTH'(MODE_OFF));
    send_rel(150);
    send_rel(250);
    send_rel(350);
    send_rel(450);
    send_rel(550);
    send_rel(2000);

    wait_idle();
    apb_write(3'd0, DATA_WIDTH'(MODE_NINETY));
    send_rel(50);
    send_rel(100);
    send_rel(900);

    wait_idle();
    apb_write(3'd0, DATA_WIDTH'(MODE_ON));
    send_tick($urandom());
    wait_idle();
    apb_write(3'd0, DATA_WIDTH'(MODE_OFF));
    send_tick($urandom());
    wait_idle();
    apb_write(3'd0, DATA_WIDTH'(MODE_DOUBLE));
    send_rel(250);
    send_rel(32'hFFFF_FFFF);
    send_rel(5);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      pm = phase < 8 ? mode_t'(phase) : mode_t'($urandom_range(0, 7));
      wval = $urandom_range(0, 1) ? DATA_WIDTH'(pm)
                                  : (DATA_WIDTH'($urandom()) & 32'hFFFF_FFF8) | DATA_WIDTH'(pm);
      apb_write(3'd0, wval);
      if ($urandom_range(0, 3) == 0) begin
        apb_write(3'd4, $urandom());
      end
      t = (phase % 3 == 0) ? 32'hFFFF_F800 + $urandom_range(0, 1500) : $urandom();
      phase_len = $urandom_range(30, 50);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0, 1, 2: t = t + $urandom_range(1, 120);
          3, 4, 5: t = sb.period_start + landmarks[$urandom_range(0, 9)]
                       - $urandom_range(0, 1);
          6: t = t + $urandom_range(1, 2100);
          7: t = t + 1;
          8: t = $urandom();
          default: t = t - $urandom_range(1, 3000);
        endcase
        send_tick(t);
        sent++;
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lbpg_pkg.sv
hdl/lbpg_level.sv
hdl/lbpg_regs.sv
hdl/led_blink_pattern_generator.sv
test/tb_led_blink_pattern_generator.sv
